@@ src/wspt_pkg.sv @@
package wspt_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned SPEED_W = 18;
	localparam int unsigned CIRC_W  = 16;
	localparam int unsigned MINI_W  = 16;
	localparam int unsigned CFG_W   = 18;
	localparam int unsigned IDX_W   = 2;
	localparam int unsigned KIND_W  = 2;

	// Dividend is circumference * 36 * 256, below 2^30 for any 16-bit circumference.
	localparam int unsigned NUM_W   = 30;
	localparam int unsigned CNT_W   = 5;

	localparam logic [SPEED_W-1:0] SPEED_SAT = 18'd262143;
	localparam logic [SPEED_W-1:0] MIN_RESET = 18'd76800;

	localparam logic [CIRC_W-1:0]  CIRC_RESET   = 16'd200;
	localparam logic [MINI_W-1:0]  MINI_RESET   = 16'd35;
	localparam logic [SPEED_W-1:0] HYST_RESET   = 18'd2560;

	localparam logic [IDX_W-1:0] REG_CIRC   = 2'd0;
	localparam logic [IDX_W-1:0] REG_LABELS = 2'd1;
	localparam logic [IDX_W-1:0] REG_MINI   = 2'd2;
	localparam logic [IDX_W-1:0] REG_HYST   = 2'd3;

	localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_PEAK   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_VALLEY = 2'd2;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DIV,
		ST_FINISH,
		ST_PEAK,
		ST_VALLEY,
		ST_SAMPLE
	} state_t;

endpackage

@@ src/wheel_speed_peak_tracker.sv @@
// Wheel speed peak tracker.
// The pulse channel (pulse_valid, pulse_stall, timestamp_ms) carries one request per wheel
// pulse, a free-running millisecond timestamp. The result channel (result_valid,
// result_stall and the four result fields) returns a speed sample for every pulse that
// passes the noise check, preceded where due by a peak report, a valley report or both.
// The sample always carries last = 1. A pulse that comes too soon after the last good
// one is dropped at once and gives no result.
// Speed comes from one restoring divider that produces one quotient bit per cycle of
// the 30-bit quotient. A finishing state then updates the trackers and makes the report
// decisions, and each result then passes through the output register. A new request
// is taken the cycle after the sample has been loaded into the output register, and
// pulse_stall is high for the whole of the division, finishing and result steps.
// A stall on the result channel holds the output register and simply pauses the
// sequencer; nothing is lost. Reset clears the output valid flag, loads the register
// defaults (200 cm, reports on, 35 ms, 2560) and returns the trackers to their
// initial state with no time origin. Configuration writes are taken at any time but
// are meant for when the block is idle.
module wheel_speed_peak_tracker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              pulse_valid,
	output logic                              pulse_stall,
	input  logic [wspt_pkg::TIME_W-1:0]       timestamp_ms,
	output logic                              result_valid,
	input  logic                              result_stall,
	output logic [wspt_pkg::KIND_W-1:0]       result_kind,
	output logic [wspt_pkg::TIME_W-1:0]       rel_time_ms,
	output logic [wspt_pkg::SPEED_W-1:0]      speed_value,
	output logic                              last,
	input  logic                              cfg_we,
	input  logic [wspt_pkg::IDX_W-1:0]        cfg_index,
	input  logic [wspt_pkg::CFG_W-1:0]        cfg_data
);

	// Configuration registers.
	logic [wspt_pkg::CIRC_W-1:0]  circ_q;
	logic                         labels_q;
	logic [wspt_pkg::MINI_W-1:0]  mini_q;
	logic [wspt_pkg::SPEED_W-1:0] hyst_q;

	// Tracker state that lives from pulse to pulse.
	logic [wspt_pkg::TIME_W-1:0]  prev_q;
	logic [wspt_pkg::TIME_W-1:0]  origin_q;
	logic                         origin_vld_q;
	logic [wspt_pkg::SPEED_W-1:0] min_q;
	logic [wspt_pkg::SPEED_W-1:0] max_q;
	logic [wspt_pkg::TIME_W-1:0]  min_t_q;
	logic [wspt_pkg::TIME_W-1:0]  max_t_q;
	logic                         seek_q;

	// Per-pulse working registers.
	wspt_pkg::state_t             state_q, state_d;
	logic [wspt_pkg::TIME_W-1:0]  t_q;
	logic [wspt_pkg::TIME_W-1:0]  rel_q;
	logic [wspt_pkg::TIME_W-1:0]  den_q;
	logic [wspt_pkg::TIME_W-1:0]  rem_q;
	logic [wspt_pkg::NUM_W-1:0]   num_q;
	logic [wspt_pkg::CNT_W-1:0]   cnt_q;
	logic [wspt_pkg::SPEED_W-1:0] spd_q;
	logic                         vl_q;
	logic [wspt_pkg::SPEED_W-1:0] pk_val_q;
	logic [wspt_pkg::TIME_W-1:0]  pk_t_q;
	logic [wspt_pkg::SPEED_W-1:0] vl_val_q;
	logic [wspt_pkg::TIME_W-1:0]  vl_t_q;

	// Output register.
	logic                         out_vld_q;
	logic [wspt_pkg::KIND_W-1:0]  out_kind_q;
	logic [wspt_pkg::TIME_W-1:0]  out_time_q;
	logic [wspt_pkg::SPEED_W-1:0] out_val_q;
	logic                         out_last_q;

	logic                         accept;
	logic [wspt_pkg::TIME_W-1:0]  origin_eff;
	logic [wspt_pkg::TIME_W-1:0]  interval;
	logic                         too_soon;
	logic [wspt_pkg::NUM_W-1:0]   numer;

	logic [wspt_pkg::TIME_W:0]    trial;
	logic                         qbit;

	logic [wspt_pkg::SPEED_W-1:0] spd;
	logic [wspt_pkg::SPEED_W-1:0] min1, max1, min2, max2;
	logic [wspt_pkg::TIME_W-1:0]  min_t1, max_t1;
	logic [wspt_pkg::SPEED_W-1:0] pk_diff;
	logic [wspt_pkg::SPEED_W-1:0] vl_diff;
	logic                         pk_fire, vl_fire, seek2;

	logic                         out_free;
	logic                         out_load;
	logic [wspt_pkg::KIND_W-1:0]  out_kind_d;
	logic [wspt_pkg::TIME_W-1:0]  out_time_d;
	logic [wspt_pkg::SPEED_W-1:0] out_val_d;
	logic                         out_last_d;

	assign accept     = pulse_valid && !pulse_stall;
	// The very first pulse is its own origin.
	assign origin_eff = origin_vld_q ? origin_q : timestamp_ms;
	assign interval   = timestamp_ms - prev_q;
	assign too_soon   = interval < {{(wspt_pkg::TIME_W-wspt_pkg::MINI_W){1'b0}}, mini_q};
	// circumference * 9216 = circumference * (8192 + 1024).
	assign numer      = (wspt_pkg::NUM_W'(circ_q) << 13) + (wspt_pkg::NUM_W'(circ_q) << 10);

	// One restoring division step: bring down the next dividend bit and try the divisor.
	assign trial = {rem_q, num_q[wspt_pkg::NUM_W-1]};
	assign qbit  = trial >= {1'b0, den_q};

	// Tracker update, evaluated in the finishing cycle once the quotient is complete.
	// A zero interval divides to all ones and so saturates as well.
	always_comb begin
		if (num_q[wspt_pkg::NUM_W-1:wspt_pkg::SPEED_W] != '0) begin
			spd = wspt_pkg::SPEED_SAT;
		end else begin
			spd = num_q[wspt_pkg::SPEED_W-1:0];
		end
		min1   = (spd < min_q) ? spd : min_q;
		min_t1 = (spd < min_q) ? rel_q : min_t_q;
		max1   = (spd > max_q) ? spd : max_q;
		max_t1 = (spd > max_q) ? rel_q : max_t_q;
		// max1 is never below the current speed, so the difference cannot go negative.
		pk_diff = max1 - spd;
		pk_fire = labels_q && seek_q && (pk_diff > hyst_q);
		min2    = pk_fire ? wspt_pkg::MIN_RESET : min1;
		max2    = pk_fire ? '0 : max1;
		seek2   = pk_fire ? 1'b0 : seek_q;
		// The valley check sees the trackers as the peak check may just have left them.
		vl_diff = spd - min2;
		vl_fire = labels_q && !seek2 && (spd > min2) && (vl_diff > hyst_q);
	end

	assign out_free = !out_vld_q || !result_stall;

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			wspt_pkg::ST_IDLE: begin
				if (pulse_valid && !too_soon) begin
					state_d = wspt_pkg::ST_DIV;
				end
			end
			wspt_pkg::ST_DIV: begin
				if (cnt_q == wspt_pkg::CNT_W'(wspt_pkg::NUM_W - 1)) begin
					state_d = wspt_pkg::ST_FINISH;
				end
			end
			wspt_pkg::ST_FINISH: begin
				if (pk_fire) begin
					state_d = wspt_pkg::ST_PEAK;
				end else if (vl_fire) begin
					state_d = wspt_pkg::ST_VALLEY;
				end else begin
					state_d = wspt_pkg::ST_SAMPLE;
				end
			end
			wspt_pkg::ST_PEAK: begin
				if (out_free) begin
					state_d = vl_q ? wspt_pkg::ST_VALLEY : wspt_pkg::ST_SAMPLE;
				end
			end
			wspt_pkg::ST_VALLEY: begin
				if (out_free) begin
					state_d = wspt_pkg::ST_SAMPLE;
				end
			end
			wspt_pkg::ST_SAMPLE: begin
				if (out_free) begin
					state_d = wspt_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = wspt_pkg::ST_IDLE;
			end
		endcase
	end

	// State outputs: pulse channel stall and what goes into the output register.
	always_comb begin
		pulse_stall = 1'b1;
		out_load    = 1'b0;
		out_kind_d  = wspt_pkg::KIND_SAMPLE;
		out_time_d  = rel_q;
		out_val_d   = spd_q;
		out_last_d  = 1'b0;
		case (state_q)
			wspt_pkg::ST_IDLE: begin
				pulse_stall = 1'b0;
			end
			wspt_pkg::ST_PEAK: begin
				out_load   = out_free;
				out_kind_d = wspt_pkg::KIND_PEAK;
				out_time_d = pk_t_q;
				out_val_d  = pk_val_q;
			end
			wspt_pkg::ST_VALLEY: begin
				out_load   = out_free;
				out_kind_d = wspt_pkg::KIND_VALLEY;
				out_time_d = vl_t_q;
				out_val_d  = vl_val_q;
			end
			wspt_pkg::ST_SAMPLE: begin
				out_load   = out_free;
				out_last_d = 1'b1;
			end
			default: begin
				pulse_stall = 1'b1;
			end
		endcase
	end

	// Sequencer, configuration and tracker state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= wspt_pkg::ST_IDLE;
			circ_q       <= wspt_pkg::CIRC_RESET;
			labels_q     <= 1'b1;
			mini_q       <= wspt_pkg::MINI_RESET;
			hyst_q       <= wspt_pkg::HYST_RESET;
			prev_q       <= '0;
			origin_q     <= '0;
			origin_vld_q <= 1'b0;
			min_q        <= wspt_pkg::MIN_RESET;
			max_q        <= '0;
			min_t_q      <= '0;
			max_t_q      <= '0;
			seek_q       <= 1'b1;
			out_vld_q    <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					wspt_pkg::REG_CIRC:   circ_q   <= cfg_data[wspt_pkg::CIRC_W-1:0];
					wspt_pkg::REG_LABELS: labels_q <= cfg_data[0];
					wspt_pkg::REG_MINI:   mini_q   <= cfg_data[wspt_pkg::MINI_W-1:0];
					wspt_pkg::REG_HYST:   hyst_q   <= cfg_data;
					default: begin
					end
				endcase
			end
			// The origin is set by the first pulse even when that pulse is dropped.
			if (accept) begin
				origin_q     <= origin_eff;
				origin_vld_q <= 1'b1;
			end
			if (state_q == wspt_pkg::ST_FINISH) begin
				prev_q  <= t_q;
				min_t_q <= min_t1;
				max_t_q <= max_t1;
				min_q   <= vl_fire ? wspt_pkg::MIN_RESET : min2;
				max_q   <= vl_fire ? '0 : max2;
				seek_q  <= vl_fire ? 1'b1 : seek2;
			end
			if (out_load) begin
				out_vld_q <= 1'b1;
			end else if (!result_stall) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Divider and per-pulse payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			t_q   <= timestamp_ms;
			rel_q <= timestamp_ms - origin_eff;
			den_q <= interval;
			rem_q <= '0;
			num_q <= numer;
			cnt_q <= '0;
		end
		if (state_q == wspt_pkg::ST_DIV) begin
			rem_q <= qbit ? wspt_pkg::TIME_W'(trial - {1'b0, den_q})
			              : trial[wspt_pkg::TIME_W-1:0];
			num_q <= {num_q[wspt_pkg::NUM_W-2:0], qbit};
			cnt_q <= cnt_q + wspt_pkg::CNT_W'(1);
		end
		if (state_q == wspt_pkg::ST_FINISH) begin
			spd_q    <= spd;
			vl_q     <= vl_fire;
			pk_val_q <= max1;
			pk_t_q   <= max_t1;
			vl_val_q <= min2;
			vl_t_q   <= min_t1;
		end
		if (out_load) begin
			out_kind_q <= out_kind_d;
			out_time_q <= out_time_d;
			out_val_q  <= out_val_d;
			out_last_q <= out_last_d;
		end
	end

	assign result_valid = out_vld_q;
	assign result_kind  = out_kind_q;
	assign rel_time_ms  = out_time_q;
	assign speed_value  = out_val_q;
	assign last         = out_last_q;

endmodule
